>>> hdl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar time counter package
// Codes and field limits that are shared by the counter, its checker and its
// testbench, and the BCD helper that the counter uses.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] FLD_SEC     = 3'd0;
  localparam logic [2:0] FLD_MIN     = 3'd1;
  localparam logic [2:0] FLD_HOUR    = 3'd2;
  localparam logic [2:0] FLD_WEEKDAY = 3'd3;
  localparam logic [2:0] FLD_DAY     = 3'd4;
  localparam logic [2:0] FLD_MONTH   = 3'd5;
  localparam logic [2:0] FLD_YEAR    = 3'd6;
  localparam logic [2:0] FLD_UNKNOWN = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE_ERR = 2'd1;
  localparam logic [1:0] ST_FIELD_ERR = 2'd2;

  localparam logic [5:0] SEC_MAX     = 6'd59;
  localparam logic [5:0] MIN_MAX     = 6'd59;
  localparam logic [4:0] HOUR_MAX    = 5'd23;
  localparam logic [2:0] WEEKDAY_MAX = 3'd7;
  localparam logic [4:0] DAY_MAX     = 5'd31;
  localparam logic [3:0] MONTH_MAX   = 4'd12;
  localparam logic [6:0] YEAR_MAX    = 7'd99;

  // Two packed BCD digits of a value below 100; tens by reciprocal 205/2048.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - 7'({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

>>> hdl/calendar_time_counter_unit.sv
// ----------------------------------------------------------------------------
// Calendar time counter unit
// Seconds through two-digit year counter with tick and field-write items.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle and returns its result item in the next cycle.
// A tick item (tuser = 0) advances the time by one second, carrying through
// minutes, hours, day (every month has 31 days), month and year; the weekday
// is never advanced. A write item (tuser = 1) loads one field if the value is
// in range and otherwise reports a range or unknown-field status. Each result
// carries the complete time in packed BCD. The counters and the result
// register are updated in the same cycle, so the rate is set by that single
// register stage; the input stalls only while a result waits on m_axis_tready.
module calendar_time_counter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // field [2:0], value [10:3], zero [15:11]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // seconds_bcd [6:0], minutes_bcd [13:7],
                                      // hours_bcd [19:14], weekday_out [22:20],
                                      // day_bcd [28:23], month_bcd [33:29],
                                      // year_bcd [41:34], status [43:42],
                                      // zero [47:44]
);

  logic [5:0] sec_count,  sec_count_next;
  logic [5:0] min_count,  min_count_next;
  logic [4:0] hour_count, hour_count_next;
  logic [2:0] weekday_reg, weekday_reg_next;
  logic [4:0] day_count,  day_count_next;
  logic [3:0] month_count, month_count_next;
  logic [6:0] year_count, year_count_next;
  logic [1:0] status_next;

  logic       in_acc;
  logic [2:0] field;
  logic [7:0] value;
  logic       sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap, year_wrap;
  logic       c_min, c_hour, c_day, c_month, c_year;

  logic [7:0] sec_bcd, min_bcd, hour_bcd, day_bcd, month_bcd, year_bcd;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign field         = s_axis_tdata[2:0];
  assign value         = s_axis_tdata[10:3];

  assign sec_wrap   = (sec_count == ctc_pkg::SEC_MAX);
  assign min_wrap   = (min_count == ctc_pkg::MIN_MAX);
  assign hour_wrap  = (hour_count == ctc_pkg::HOUR_MAX);
  assign day_wrap   = (day_count == ctc_pkg::DAY_MAX);
  assign month_wrap = (month_count >= ctc_pkg::MONTH_MAX);
  assign year_wrap  = (year_count >= ctc_pkg::YEAR_MAX);

  assign c_min   = sec_wrap;
  assign c_hour  = c_min && min_wrap;
  assign c_day   = c_hour && hour_wrap;
  assign c_month = c_day && day_wrap;
  assign c_year  = c_month && month_wrap;

  always_comb begin
    sec_count_next   = sec_count;
    min_count_next   = min_count;
    hour_count_next  = hour_count;
    weekday_reg_next = weekday_reg;
    day_count_next   = day_count;
    month_count_next = month_count;
    year_count_next  = year_count;
    status_next      = ctc_pkg::ST_OK;

    if (s_axis_tuser == ctc_pkg::OP_TICK) begin
      sec_count_next = sec_wrap ? 6'd0 : sec_count + 6'd1;
      if (c_min) begin
        min_count_next = min_wrap ? 6'd0 : min_count + 6'd1;
      end
      if (c_hour) begin
        hour_count_next = hour_wrap ? 5'd0 : hour_count + 5'd1;
      end
      // day and month restart at 1, so a zero left from reset steps to 1
      if (c_day) begin
        day_count_next = day_wrap ? 5'd1 : day_count + 5'd1;
      end
      if (c_month) begin
        month_count_next = month_wrap ? 4'd1 : month_count + 4'd1;
      end
      if (c_year) begin
        year_count_next = year_wrap ? 7'd0 : year_count + 7'd1;
      end
    end else begin
      case (field)
        ctc_pkg::FLD_SEC: begin
          if (value <= {2'd0, ctc_pkg::SEC_MAX}) sec_count_next = value[5:0];
          else status_next = ctc_pkg::ST_RANGE_ERR;
        end
        ctc_pkg::FLD_MIN: begin
          if (value <= {2'd0, ctc_pkg::MIN_MAX}) min_count_next = value[5:0];
          else status_next = ctc_pkg::ST_RANGE_ERR;
        end
        ctc_pkg::FLD_HOUR: begin
          if (value <= {3'd0, ctc_pkg::HOUR_MAX}) hour_count_next = value[4:0];
          else status_next = ctc_pkg::ST_RANGE_ERR;
        end
        ctc_pkg::FLD_WEEKDAY: begin
          if (value != 8'd0 && value <= {5'd0, ctc_pkg::WEEKDAY_MAX}) begin
            weekday_reg_next = value[2:0];
          end else begin
            status_next = ctc_pkg::ST_RANGE_ERR;
          end
        end
        ctc_pkg::FLD_DAY: begin
          if (value != 8'd0 && value <= {3'd0, ctc_pkg::DAY_MAX}) begin
            day_count_next = value[4:0];
          end else begin
            status_next = ctc_pkg::ST_RANGE_ERR;
          end
        end
        ctc_pkg::FLD_MONTH: begin
          if (value != 8'd0 && value <= {4'd0, ctc_pkg::MONTH_MAX}) begin
            month_count_next = value[3:0];
          end else begin
            status_next = ctc_pkg::ST_RANGE_ERR;
          end
        end
        ctc_pkg::FLD_YEAR: begin
          if (value <= {1'd0, ctc_pkg::YEAR_MAX}) year_count_next = value[6:0];
          else status_next = ctc_pkg::ST_RANGE_ERR;
        end
        default: begin
          status_next = ctc_pkg::ST_FIELD_ERR;
        end
      endcase
    end
  end

  assign sec_bcd   = ctc_pkg::to_bcd({1'b0, sec_count_next});
  assign min_bcd   = ctc_pkg::to_bcd({1'b0, min_count_next});
  assign hour_bcd  = ctc_pkg::to_bcd({2'd0, hour_count_next});
  assign day_bcd   = ctc_pkg::to_bcd({2'd0, day_count_next});
  assign month_bcd = ctc_pkg::to_bcd({3'd0, month_count_next});
  assign year_bcd  = ctc_pkg::to_bcd(year_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_count     <= '0;
      min_count     <= '0;
      hour_count    <= '0;
      weekday_reg   <= '0;
      day_count     <= '0;
      month_count   <= '0;
      year_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (in_acc) begin
      sec_count     <= sec_count_next;
      min_count     <= min_count_next;
      hour_count    <= hour_count_next;
      weekday_reg   <= weekday_reg_next;
      day_count     <= day_count_next;
      month_count   <= month_count_next;
      year_count    <= year_count_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // hold the result until taken; a new item overwrites only when accepted
  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_axis_tdata <= {4'd0, status_next, year_bcd, month_bcd[4:0], day_bcd[5:0],
                       weekday_reg_next, hour_bcd[5:0], min_bcd[6:0], sec_bcd[6:0]};
    end
  end

endmodule

>>> hdl/ctc_checker.sv
// ----------------------------------------------------------------------------
// Calendar time counter checker
// Port-level properties of the counter, bound into the counter module.
// ----------------------------------------------------------------------------
module ctc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a waiting result blocks the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  a_tick_ok: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == ctc_pkg::OP_TICK) |=>
      (m_axis_tvalid && m_axis_tdata[43:42] == ctc_pkg::ST_OK))
    else $error("tick item without ok result");

  a_unknown: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == ctc_pkg::OP_WRITE
      && s_axis_tdata[2:0] == ctc_pkg::FLD_UNKNOWN) |=>
      (m_axis_tvalid && m_axis_tdata[43:42] == ctc_pkg::ST_FIELD_ERR))
    else $error("unknown field not reported");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_axis_tuser == ctc_pkg::OP_WRITE
      && s_axis_tdata[2:0] == ctc_pkg::FLD_WEEKDAY
      && s_axis_tdata[10:3] != 8'd0
      && s_axis_tdata[10:3] <= {5'd0, ctc_pkg::WEEKDAY_MAX}) |=>
      (m_axis_tdata[22:20] == $past(s_axis_tdata[5:3])))
    else $error("weekday write not reflected");

  a_sec_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9 && m_axis_tdata[6:4] <= 3'd5))
    else $error("seconds BCD out of range");

endmodule

bind calendar_time_counter_unit ctc_checker u_ctc_checker (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Calendar time counter testbench
// Drives tick and field-write items into the counter with bursty input and a
// stalling output. A running copy of the calendar predicts every result, and
// the results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic       op;
    logic [2:0] sel;
    logic [7:0] val;
  } cal_item_t;

  typedef struct packed {
    logic [6:0] sec_bcd;
    logic [6:0] min_bcd;
    logic [5:0] hour_bcd;
    logic [2:0] wday;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    logic [1:0] status;
  } time_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // field [2:0], value [10:3], zero [15:11]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // seconds_bcd, minutes_bcd, hours_bcd,
                                    // weekday_out, day_bcd, month_bcd,
                                    // year_bcd, status (lowest first)

  cal_item_t    stim_q[$];
  time_result_t calendar_q[$];
  cal_item_t    cur_item;

  // Predicted calendar state
  int t_sec, t_min, t_hour, t_wday, t_day, t_month, t_year;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int n_ticks = 0, n_writes = 0, n_range_err = 0, n_field_err = 0;
  int n_year_wraps = 0, n_results = 0;
  int burst_left = 0, gap_left = 0;
  int rdy_left = 0, rdy_mode = 0;

  calendar_time_counter_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] pack_bcd(input int v);
    int x;
    x = v % 100;
    return 8'(((x / 10) << 4) | (x % 10));
  endfunction

  // Update the calendar copy with one item and return the expected result.
  function automatic time_result_t predict_calendar(input cal_item_t it);
    time_result_t r;
    logic [1:0]   st;
    int           lo, hi, v;
    st = ctc_pkg::ST_OK;
    v  = int'(it.val);
    lo = 0;
    hi = 0;
    if (it.op == ctc_pkg::OP_TICK) begin
      n_ticks++;
      t_sec++;
      if (t_sec >= 60) begin
        t_sec = 0;
        t_min++;
        if (t_min >= 60) begin
          t_min = 0;
          t_hour++;
          if (t_hour >= 24) begin
            t_hour = 0;
            t_day++;
            if (t_day > 31) begin
              t_day = 1;
              t_month++;
              if (t_month > 12) begin
                t_month = 1;
                t_year++;
                if (t_year > 99) begin
                  t_year = 0;
                  n_year_wraps++;
                end
              end
            end
          end
        end
      end
    end else begin
      n_writes++;
      case (it.sel)
        ctc_pkg::FLD_SEC, ctc_pkg::FLD_MIN: begin lo = 0; hi = 59; end
        ctc_pkg::FLD_HOUR:    begin lo = 0; hi = 23; end
        ctc_pkg::FLD_WEEKDAY: begin lo = 1; hi = 7;  end
        ctc_pkg::FLD_DAY:     begin lo = 1; hi = 31; end
        ctc_pkg::FLD_MONTH:   begin lo = 1; hi = 12; end
        ctc_pkg::FLD_YEAR:    begin lo = 0; hi = 99; end
        default:              st = ctc_pkg::ST_FIELD_ERR;
      endcase
      if (st == ctc_pkg::ST_FIELD_ERR) begin
        n_field_err++;
      end else if (v < lo || v > hi) begin
        st = ctc_pkg::ST_RANGE_ERR;
        n_range_err++;
      end else begin
        case (it.sel)
          ctc_pkg::FLD_SEC:     t_sec   = v;
          ctc_pkg::FLD_MIN:     t_min   = v;
          ctc_pkg::FLD_HOUR:    t_hour  = v;
          ctc_pkg::FLD_WEEKDAY: t_wday  = v;
          ctc_pkg::FLD_DAY:     t_day   = v;
          ctc_pkg::FLD_MONTH:   t_month = v;
          ctc_pkg::FLD_YEAR:    t_year  = v;
          default:              ;
        endcase
      end
    end
    r.sec_bcd   = 7'(pack_bcd(t_sec));
    r.min_bcd   = 7'(pack_bcd(t_min));
    r.hour_bcd  = 6'(pack_bcd(t_hour));
    r.wday      = 3'(t_wday);
    r.day_bcd   = 6'(pack_bcd(t_day));
    r.month_bcd = 5'(pack_bcd(t_month));
    r.year_bcd  = pack_bcd(t_year);
    r.status    = st;
    return r;
  endfunction

  task automatic push_item(input logic op, input logic [2:0] sel, input int val);
    cal_item_t it;
    it.op  = op;
    it.sel = sel;
    it.val = 8'(val);
    stim_q.push_back(it);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        calendar_q.push_back(predict_calendar(cur_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() > 0) begin
          cur_item = stim_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_item.op;
          s_axis_tdata  <= {5'd0, cur_item.val, cur_item.sel};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: segments of always-ready, coin-flip, periodic
  // and heavy stalling
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(5, 60);
    end
    rdy_left--;
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (cycle_cnt % 4 != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    time_result_t exp_r, act_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act_r.sec_bcd   = m_axis_tdata[6:0];
      act_r.min_bcd   = m_axis_tdata[13:7];
      act_r.hour_bcd  = m_axis_tdata[19:14];
      act_r.wday      = m_axis_tdata[22:20];
      act_r.day_bcd   = m_axis_tdata[28:23];
      act_r.month_bcd = m_axis_tdata[33:29];
      act_r.year_bcd  = m_axis_tdata[41:34];
      act_r.status    = m_axis_tdata[43:42];
      if (calendar_q.size() == 0) begin
        $error("result item with no expectation pending: 0x%0h", m_axis_tdata);
        err_cnt++;
      end else begin
        exp_r = calendar_q.pop_front();
        n_results++;
        check_field("seconds_bcd", int'(exp_r.sec_bcd),   int'(act_r.sec_bcd));
        check_field("minutes_bcd", int'(exp_r.min_bcd),   int'(act_r.min_bcd));
        check_field("hours_bcd",   int'(exp_r.hour_bcd),  int'(act_r.hour_bcd));
        check_field("weekday_out", int'(exp_r.wday),      int'(act_r.wday));
        check_field("day_bcd",     int'(exp_r.day_bcd),   int'(act_r.day_bcd));
        check_field("month_bcd",   int'(exp_r.month_bcd), int'(act_r.month_bcd));
        check_field("year_bcd",    int'(exp_r.year_bcd),  int'(act_r.year_bcd));
        check_field("status",      int'(exp_r.status),    int'(act_r.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, calendar_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int kind;
    int n_gen;
    t_sec = 0; t_min = 0; t_hour = 0; t_wday = 0;
    t_day = 0; t_month = 0; t_year = 0;

    // Day carry from the zero day after reset, month still zero
    push_item(ctc_pkg::OP_TICK,  ctc_pkg::FLD_SEC,  0);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_SEC,  59);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MIN,  59);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_HOUR, 23);
    push_item(ctc_pkg::OP_TICK,  ctc_pkg::FLD_SEC,  0);
    // Month carry out of the zero month
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_DAY,  31);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_SEC,  59);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MIN,  59);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_HOUR, 23);
    push_item(ctc_pkg::OP_TICK,  ctc_pkg::FLD_SEC,  0);
    // Full cascade through the year wrap
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MONTH, 12);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_YEAR,  99);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_DAY,   31);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_SEC,   59);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MIN,   59);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_HOUR,  23);
    push_item(ctc_pkg::OP_TICK,  ctc_pkg::FLD_YEAR,  255);
    // Weekday limits, out-of-range writes and the unknown field
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_WEEKDAY, 7);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_WEEKDAY, 0);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_WEEKDAY, 1);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_SEC,     60);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_HOUR,    24);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MONTH,   13);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_DAY,     0);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_YEAR,    255);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_UNKNOWN, 255);
    push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_YEAR,    0);

    n_gen = 0;
    while (n_gen < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        // Park the time just short of a carry, then tick towards and usually across it
        push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_SEC, $urandom_range(50, 59));
        n_gen++;
        if ($urandom_range(0, 1) == 0) begin
          push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MIN, $urandom_range(57, 59));
          n_gen++;
        end
        if ($urandom_range(0, 2) == 0) begin
          push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_HOUR, $urandom_range(22, 23));
          n_gen++;
        end
        if ($urandom_range(0, 3) == 0) begin
          push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_DAY, $urandom_range(30, 31));
          n_gen++;
        end
        if ($urandom_range(0, 4) == 0) begin
          push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_MONTH, $urandom_range(11, 12));
          n_gen++;
        end
        if ($urandom_range(0, 5) == 0) begin
          push_item(ctc_pkg::OP_WRITE, ctc_pkg::FLD_YEAR, $urandom_range(98, 99));
          n_gen++;
        end
        repeat ($urandom_range(5, 15)) begin
          push_item(ctc_pkg::OP_TICK, 3'($urandom_range(0, 7)), $urandom_range(0, 255));
          n_gen++;
        end
      end else if (kind < 7) begin
        push_item(ctc_pkg::OP_WRITE, 3'($urandom_range(0, 6)), $urandom_range(0, 63));
        n_gen++;
      end else if (kind < 9) begin
        push_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  $urandom_range(0, 255));
        n_gen++;
      end else begin
        repeat ($urandom_range(1, 70)) begin
          push_item(ctc_pkg::OP_TICK, 3'($urandom_range(0, 7)), $urandom_range(0, 255));
          n_gen++;
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, every result back, then a short settle
    while (stim_q.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (calendar_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d ticks and %0d writes (%0d out of range, %0d unknown field)",
             n_ticks, n_writes, n_range_err, n_field_err);
    $display("checked %0d results, year wrapped %0d times, %0d mismatches",
             n_results, n_year_wraps, err_cnt);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> calendar_time_counter_unit.f
hdl/ctc_pkg.sv
hdl/calendar_time_counter_unit.sv
hdl/ctc_checker.sv
dv/tb_top.sv
